[rtl/slice_quantiser_estimate_histogram_unit_macros.svh]
// Assertion macros shared by the slice quantiser estimate histogram unit.
`ifndef SLICE_QUANTISER_ESTIMATE_HISTOGRAM_UNIT_MACROS_SVH
`define SLICE_QUANTISER_ESTIMATE_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SQEH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqeh assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define SQEH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqeh assertion failed");

`endif

[rtl/sqeh_pkg.sv]
// Shared types, constants and functions of the slice quantiser estimate histogram unit.
`default_nettype none

package sqeh_pkg;

    localparam int NUM_SUBBANDS = 7;
    localparam int SB_W         = 3;
    localparam int OR_W         = 16;
    localparam int Q_W          = 5;
    localparam int COUNT_W      = 32;
    localparam int BIN_IDX_W    = 5;
    localparam int KIND_W       = 2;
    localparam int POS_W        = 3;

    // Largest quantiser the estimate can produce.
    localparam logic [Q_W-1:0] Q_MAX = 5'd28;

    // Input transaction kinds.
    localparam logic [KIND_W-1:0] KIND_COEFF = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Per-subband offset added to a nonzero term.
    localparam logic [Q_W-1:0] SB_OFFSET [NUM_SUBBANDS] =
        '{5'd4, 5'd2, 5'd2, 5'd0, 5'd4, 5'd4, 5'd2};

    // Histogram operations.
    typedef enum logic [1:0] {
        HOP_INC   = 2'd0,
        HOP_READ  = 2'd1,
        HOP_CLEAR = 2'd2
    } hist_op_t;

    // Request from the front stage to the histogram stage.
    typedef struct packed {
        hist_op_t               op;
        logic [Q_W-1:0]         quantiser;
        logic [BIN_IDX_W-1:0]   bin_index;
    } hist_req_t;

    // Subband of a coefficient from its position modulo four.
    function automatic logic [SB_W-1:0] pick_subband(input logic [1:0] r, input logic [1:0] c);
        logic [SB_W-1:0] sb;
        if (!r[0]) begin
            if (!c[0]) begin
                sb = {1'b0, r[1], c[1]};
            end else begin
                sb = 3'd4;
            end
        end else begin
            sb = c[0] ? 3'd6 : 3'd5;
        end
        return sb;
    endfunction

    // Term 4*(bit_length-10) when the bit length exceeds ten, else zero.
    function automatic logic [Q_W-1:0] len_term(input logic [OR_W-1:0] v);
        logic [Q_W-1:0] t;
        priority if (v[15]) t = 5'd24;
        else if (v[14])     t = 5'd20;
        else if (v[13])     t = 5'd16;
        else if (v[12])     t = 5'd12;
        else if (v[11])     t = 5'd8;
        else if (v[10])     t = 5'd4;
        else                t = 5'd0;
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/slice_quantiser_estimate_histogram_unit.sv]
// Top level of the slice quantiser estimate histogram unit.
//
// Usage: transactions enter on the item channel (item_valid/item_ready) and
// results leave on the result channel (result_valid/result_ready).
// A coefficient transaction (kind 0) folds 1+|coeff_value| into the subband
// picked by row and col. With end_of_group set, it also yields a quantiser
// estimate result and bumps the matching histogram bin, saturating at the
// all-ones count. A read transaction (kind 1) yields the count of bin_index.
// A clear transaction (kind 2) zeroes the histogram; it and kind 3 give no result.
// Throughput is one transaction per clock while result_ready is not held low;
// the histogram read-modify-write runs over two stages around the registered
// RAM read, with a forwarding path so back-to-back updates of one bin stay exact.
// Results pass through the input register, stage two and the result register.
// Reset clears the subband accumulators and the per-bin valid bits at once,
// so the histogram reads as all zeros with no clearing pass.
// When the receiver stalls, the result register holds and the front stages
// keep accepting until each stage holds a transaction.
`default_nettype none

`include "slice_quantiser_estimate_histogram_unit_macros.svh"

module slice_quantiser_estimate_histogram_unit #(
    parameter int HIST_BINS  = 32,
    parameter int COEFF_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire logic [sqeh_pkg::KIND_W-1:0]        kind,
    input  wire logic [sqeh_pkg::POS_W-1:0]         row,
    input  wire logic [sqeh_pkg::POS_W-1:0]         col,
    input  wire logic signed [15:0]                 coeff_value,
    input  wire logic                               end_of_group,
    input  wire logic [sqeh_pkg::BIN_IDX_W-1:0]     bin_index,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic                                    result_kind,
    output logic      [sqeh_pkg::Q_W-1:0]           quantiser,
    output logic      [sqeh_pkg::COUNT_W-1:0]       bin_count
);

    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    logic [sqeh_pkg::KIND_W-1:0]        s1_kind_reg;
    logic [sqeh_pkg::POS_W-1:0]         s1_row_reg;
    logic [sqeh_pkg::POS_W-1:0]         s1_col_reg;
    logic [COEFF_BITS-1:0]              s1_value_reg;
    logic                               s1_end_reg;
    logic [sqeh_pkg::BIN_IDX_W-1:0]     s1_bin_reg;

    logic                               needs_hist;
    logic                               s1_done;
    logic                               est_upd;
    logic [sqeh_pkg::Q_W-1:0]           best;
    logic                               hist_req_valid;
    logic                               hist_req_ready;
    sqeh_pkg::hist_req_t                hist_req;

    // Decide whether the held transaction needs the histogram stage.
    always_comb
    begin
        needs_hist  = 1'b0;
        hist_req.op = sqeh_pkg::HOP_INC;
        unique case (s1_kind_reg)
            sqeh_pkg::KIND_COEFF:
            begin
                needs_hist  = s1_end_reg;
                hist_req.op = sqeh_pkg::HOP_INC;
            end
            sqeh_pkg::KIND_READ:
            begin
                needs_hist  = 1'b1;
                hist_req.op = sqeh_pkg::HOP_READ;
            end
            sqeh_pkg::KIND_CLEAR:
            begin
                needs_hist  = 1'b1;
                hist_req.op = sqeh_pkg::HOP_CLEAR;
            end
            default:
            begin
                needs_hist  = 1'b0;
                hist_req.op = sqeh_pkg::HOP_INC;
            end
        endcase
        hist_req.quantiser = best;
        hist_req.bin_index = s1_bin_reg;
    end

    assign hist_req_valid = s1_valid_reg && needs_hist;
    assign s1_done        = s1_valid_reg && (!needs_hist || hist_req_ready);
    assign est_upd        = s1_done && (s1_kind_reg == sqeh_pkg::KIND_COEFF);
    assign item_ready     = !s1_valid_reg || s1_done;
    assign s1_valid_next  = item_ready ? item_valid : s1_valid_reg;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_kind_reg  <= kind;
            s1_row_reg   <= row;
            s1_col_reg   <= col;
            s1_value_reg <= coeff_value[COEFF_BITS-1:0];
            s1_end_reg   <= end_of_group;
            s1_bin_reg   <= bin_index;
        end
    end

    sqeh_estimate #(
        .COEFF_BITS (COEFF_BITS)
    ) u_estimate (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (est_upd),
        .row   (s1_row_reg),
        .col   (s1_col_reg),
        .value (s1_value_reg),
        .last  (s1_end_reg),
        .best  (best)
    );

    sqeh_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (hist_req_valid),
        .req_ready    (hist_req_ready),
        .req          (hist_req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .quantiser    (quantiser),
        .bin_count    (bin_count)
    );

    // Checks on the estimate range, the result payload and stall behavior.
    `SQEH_ASSERT_IMPLY(a_q_range, result_valid && !result_kind, quantiser <= sqeh_pkg::Q_MAX)
    `SQEH_ASSERT_IMPLY(a_payload_zero, result_valid,
        (result_kind && quantiser == '0) || (!result_kind && bin_count == '0))
    `SQEH_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_done,
        s1_valid_reg && $stable(s1_kind_reg) && $stable(s1_bin_reg))
    `SQEH_ASSERT_NEXT(a_out_hold, result_valid && !result_ready,
        result_valid && $stable(bin_count) && $stable(quantiser))

endmodule

`default_nettype wire

[rtl/sqeh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sqeh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/sqeh_estimate.sv]
// Subband OR accumulators and the end-of-group quantiser estimate.
`default_nettype none

module sqeh_estimate #(
    parameter int COEFF_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           upd,
    input  wire logic [sqeh_pkg::POS_W-1:0]     row,
    input  wire logic [sqeh_pkg::POS_W-1:0]     col,
    input  wire logic [COEFF_BITS-1:0]          value,
    input  wire logic                           last,
    output logic      [sqeh_pkg::Q_W-1:0]       best
);

    logic [COEFF_BITS-1:0]         mag;
    logic [sqeh_pkg::OR_W-1:0]     term;
    logic [sqeh_pkg::SB_W-1:0]     sb;
    logic [sqeh_pkg::OR_W-1:0]     or_reg    [sqeh_pkg::NUM_SUBBANDS];
    logic [sqeh_pkg::OR_W-1:0]     or_next   [sqeh_pkg::NUM_SUBBANDS];
    logic [sqeh_pkg::OR_W-1:0]     merged    [sqeh_pkg::NUM_SUBBANDS];
    logic [sqeh_pkg::Q_W-1:0]      score     [sqeh_pkg::NUM_SUBBANDS];

    // Magnitude plus one; the most negative value maps to its own magnitude.
    assign mag  = value[COEFF_BITS-1] ? (~value + COEFF_BITS'(1)) : value;
    assign term = sqeh_pkg::OR_W'(mag) + 16'd1;
    assign sb   = sqeh_pkg::pick_subband(row[1:0], col[1:0]);

    // Fold the current coefficient into its subband and score every subband.
    always_comb
    begin
        for (int i = 0; i < sqeh_pkg::NUM_SUBBANDS; i++)
        begin
            merged[i] = or_reg[i] | ((sb == sqeh_pkg::SB_W'(i)) ? term : '0);
            score[i]  = sqeh_pkg::len_term(merged[i]);
            if (score[i] != '0)
            begin
                score[i] = score[i] + sqeh_pkg::SB_OFFSET[i];
            end
            or_next[i] = last ? '0 : merged[i];
        end
    end

    // Maximum over the seven subband terms.
    always_comb
    begin
        best = '0;
        for (int i = 0; i < sqeh_pkg::NUM_SUBBANDS; i++)
        begin
            if (score[i] > best)
            begin
                best = score[i];
            end
        end
    end

    // Accumulators advance once per coefficient and clear at group end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sqeh_pkg::NUM_SUBBANDS; i++)
            begin
                or_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            for (int i = 0; i < sqeh_pkg::NUM_SUBBANDS; i++)
            begin
                or_reg[i] <= or_next[i];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/sqeh_hist.sv]
// Quantiser histogram: RAM read, saturating increment, bin valid bits and result register.
`default_nettype none

module sqeh_hist #(
    parameter int HIST_BINS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire sqeh_pkg::hist_req_t                req,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic                                    result_kind,
    output logic      [sqeh_pkg::Q_W-1:0]           quantiser,
    output logic      [sqeh_pkg::COUNT_W-1:0]       bin_count
);

    localparam int AW = $clog2(HIST_BINS);

    logic                           out_en;
    logic                           issue;
    logic                           clear;
    logic                           s2_fire;
    logic                           wr_en;
    logic [AW-1:0]                  req_addr;
    logic [sqeh_pkg::COUNT_W-1:0]   rdata;
    logic [sqeh_pkg::COUNT_W-1:0]   old_count;
    logic [sqeh_pkg::COUNT_W-1:0]   new_count;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    sqeh_pkg::hist_op_t             s2_op_reg;
    logic [AW-1:0]                  s2_addr_reg;
    logic [sqeh_pkg::Q_W-1:0]       s2_q_reg;
    logic                           s2_hit_reg;
    logic                           s2_vld_reg;
    logic [sqeh_pkg::COUNT_W-1:0]   wr_hold_reg;
    logic [HIST_BINS-1:0]           bin_valid_reg;
    logic [HIST_BINS-1:0]           bin_valid_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;
    logic                           result_kind_reg;
    logic [sqeh_pkg::Q_W-1:0]       quantiser_reg;
    logic [sqeh_pkg::COUNT_W-1:0]   bin_count_reg;

    // Stage flow: the result register drains, stage two drains into it.
    assign out_en    = !result_valid_reg || result_ready;
    assign req_ready = !s2_valid_reg || out_en;
    assign s2_fire   = s2_valid_reg && out_en;
    assign issue     = req_valid && req_ready && (req.op != sqeh_pkg::HOP_CLEAR);
    assign clear     = req_valid && req_ready && (req.op == sqeh_pkg::HOP_CLEAR);
    assign wr_en     = s2_fire && (s2_op_reg == sqeh_pkg::HOP_INC);
    assign req_addr  = (req.op == sqeh_pkg::HOP_READ) ? AW'(req.bin_index)
                                                      : AW'(req.quantiser);

    sqeh_ram #(
        .WIDTH (sqeh_pkg::COUNT_W),
        .DEPTH (HIST_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_addr_reg),
        .wdata (new_count),
        .re    (issue),
        .raddr (req_addr),
        .rdata (rdata)
    );

    // Current bin value: forwarded write, RAM data, or zero for an unwritten bin.
    always_comb
    begin
        if (s2_hit_reg)
        begin
            old_count = wr_hold_reg;
        end
        else if (s2_vld_reg)
        begin
            old_count = rdata;
        end
        else
        begin
            old_count = '0;
        end
        new_count = (&old_count) ? old_count : old_count + 32'd1;
    end

    // Valid bits: a clear wipes all of them, a write marks its bin.
    always_comb
    begin
        bin_valid_next = bin_valid_reg;
        if (wr_en)
        begin
            bin_valid_next[s2_addr_reg] = 1'b1;
        end
        if (clear)
        begin
            bin_valid_next = '0;
        end
    end

    assign s2_valid_next     = issue ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);
    assign result_valid_next = out_en ? s2_valid_reg : result_valid_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            bin_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg     <= s2_valid_next;
            bin_valid_reg    <= bin_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Stage two payload, captured when the RAM read is issued.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_op_reg   <= req.op;
            s2_addr_reg <= req_addr;
            s2_q_reg    <= req.quantiser;
            s2_hit_reg  <= wr_en && (s2_addr_reg == req_addr);
            s2_vld_reg  <= bin_valid_reg[req_addr];
        end
        if (wr_en)
        begin
            wr_hold_reg <= new_count;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            if (s2_op_reg == sqeh_pkg::HOP_READ)
            begin
                result_kind_reg <= 1'b1;
                quantiser_reg   <= '0;
                bin_count_reg   <= old_count;
            end
            else
            begin
                result_kind_reg <= 1'b0;
                quantiser_reg   <= s2_q_reg;
                bin_count_reg   <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign quantiser    = quantiser_reg;
    assign bin_count    = bin_count_reg;

endmodule

`default_nettype wire
